>>> hw/rtl/lepd_pkg.sv
// Package for the line-error PD yaw-rate target block.
// Holds the beat payload types, the register map, the datapath command set and
// the fixed arithmetic widths. It depends on nothing.
package lepd_pkg;

   // Register map
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PROP_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DERIV_GAIN   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RATE_ALPHA   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_RATE  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_YAW_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEARCH_RATE  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT_SIGN  = 3'd6;

   // Arithmetic widths
   localparam int RATE_BITS    = 40;                          // filtered rate
   localparam int OPA_BITS     = RATE_BITS + 1;               // multiplier A operand
   localparam int OPB_BITS     = 16;                          // multiplier B operand
   localparam int LO_BITS      = 24;                          // low slice of A
   localparam int HI_BITS      = OPA_BITS - LO_BITS;          // high slice of A
   localparam int LO_PROD_BITS = LO_BITS + OPB_BITS;
   localparam int HI_PROD_BITS = HI_BITS + OPB_BITS + 1;
   localparam int ACC_BITS     = HI_PROD_BITS + LO_BITS;
   localparam int FRAC_BITS    = 16;                          // Q0.16 / Q8.8 products
   localparam int RND_BITS     = ACC_BITS - FRAC_BITS;
   localparam int YAW_BITS     = 16;
   localparam int LIMIT_BITS   = 15;

   // Configuration registers
   typedef struct packed {
      logic [15:0] prop_gain;
      logic [15:0] deriv_gain;
      logic [15:0] rate_filter_alpha;
      logic [15:0] sample_rate_hz;
      logic [LIMIT_BITS-1:0] yaw_limit;
      logic [LIMIT_BITS-1:0] search_yaw_rate;
      logic        invert_sign;
   } cfg_type;

   // Beat payloads
   typedef struct packed {
      logic signed [15:0] position_error;
      logic               line_seen;
   } req_type;

   typedef struct packed {
      logic signed [YAW_BITS-1:0] yaw_rate_target;
      logic                       searching;
      logic                       turn_left;
   } rsp_type;

   // Datapath command set
   typedef enum logic [3:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_DIFF,
      DP_MUL_LO,
      DP_MUL_HI,
      DP_FILTER,
      DP_ROUND,
      DP_SMOOTH,
      DP_TARGET,
      DP_SEARCH
   } dp_op_type;

   typedef enum logic [1:0] {
      SRC_RATE,
      SRC_ALPHA,
      SRC_PROP,
      SRC_DERIV
   } mul_src_type;

   typedef struct packed {
      dp_op_type   op;
      mul_src_type src;
      logic        acc_clear;
   } dp_cmd_type;

endpackage

>>> hw/rtl/lepd_csr.sv
// Configuration register file for the line-error PD block.
// Uses lepd_pkg for the register map and cfg_type; flags gain writes so the
// datapath can clear its history.
module lepd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lepd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lepd_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output lepd_pkg::cfg_type                   cfg,
   output logic                                gain_clear
);

   lepd_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid & csr_ready;

   // Register decode
   always_comb begin
      cfg_in     = cfg_ff;
      gain_clear = 1'b0;
      if (wr_en) begin
         case (csr_index)
            lepd_pkg::CSR_PROP_GAIN: begin
               cfg_in.prop_gain = csr_wdata;
               gain_clear       = 1'b1;
            end
            lepd_pkg::CSR_DERIV_GAIN: begin
               cfg_in.deriv_gain = csr_wdata;
               gain_clear        = 1'b1;
            end
            lepd_pkg::CSR_RATE_ALPHA:  cfg_in.rate_filter_alpha = csr_wdata;
            lepd_pkg::CSR_SAMPLE_RATE: cfg_in.sample_rate_hz    = csr_wdata;
            lepd_pkg::CSR_YAW_LIMIT:
               cfg_in.yaw_limit = csr_wdata[lepd_pkg::LIMIT_BITS-1:0];
            lepd_pkg::CSR_SEARCH_RATE:
               cfg_in.search_yaw_rate = csr_wdata[lepd_pkg::LIMIT_BITS-1:0];
            lepd_pkg::CSR_INVERT_SIGN: cfg_in.invert_sign = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prop_gain         <= 16'd256;
         cfg_ff.deriv_gain        <= 16'd0;
         cfg_ff.rate_filter_alpha <= 16'd65535;
         cfg_ff.sample_rate_hz    <= 16'd1000;
         cfg_ff.yaw_limit         <= 15'd32767;
         cfg_ff.search_yaw_rate   <= 15'd0;
         cfg_ff.invert_sign       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/lepd_ctrl.sv
// Sequencer for the line-error PD block: runs the rate, filter and PD steps
// or the search step and owns the beat handshakes. Uses lepd_pkg.
module lepd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_line_seen,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lepd_pkg::dp_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RATE_LO,
      ST_RATE_HI,
      ST_FILTER,
      ST_ALPHA_LO,
      ST_ALPHA_HI,
      ST_ROUND_A,
      ST_SMOOTH,
      ST_KP_LO,
      ST_KP_HI,
      ST_KD_LO,
      ST_KD_HI,
      ST_ROUND_T,
      ST_TARGET,
      ST_SEARCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      out_write;

   // Output slot is free when empty or being drained this cycle
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and datapath command
   always_comb begin
      state_in      = state_ff;
      cmd.op        = lepd_pkg::DP_NONE;
      cmd.src       = lepd_pkg::SRC_RATE;
      cmd.acc_clear = 1'b0;
      out_write     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = lepd_pkg::DP_CAPTURE;
               state_in = req_line_seen ? ST_LOAD : ST_SEARCH;
            end
         end
         ST_LOAD: begin
            cmd.op   = lepd_pkg::DP_DIFF;
            state_in = ST_RATE_LO;
         end
         ST_RATE_LO: begin
            cmd.op        = lepd_pkg::DP_MUL_LO;
            cmd.src       = lepd_pkg::SRC_RATE;
            cmd.acc_clear = 1'b1;
            state_in      = ST_RATE_HI;
         end
         ST_RATE_HI: begin
            cmd.op   = lepd_pkg::DP_MUL_HI;
            cmd.src  = lepd_pkg::SRC_RATE;
            state_in = ST_FILTER;
         end
         ST_FILTER: begin
            cmd.op   = lepd_pkg::DP_FILTER;
            state_in = ST_ALPHA_LO;
         end
         ST_ALPHA_LO: begin
            cmd.op        = lepd_pkg::DP_MUL_LO;
            cmd.src       = lepd_pkg::SRC_ALPHA;
            cmd.acc_clear = 1'b1;
            state_in      = ST_ALPHA_HI;
         end
         ST_ALPHA_HI: begin
            cmd.op   = lepd_pkg::DP_MUL_HI;
            cmd.src  = lepd_pkg::SRC_ALPHA;
            state_in = ST_ROUND_A;
         end
         ST_ROUND_A: begin
            cmd.op   = lepd_pkg::DP_ROUND;
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            cmd.op   = lepd_pkg::DP_SMOOTH;
            state_in = ST_KP_LO;
         end
         ST_KP_LO: begin
            cmd.op        = lepd_pkg::DP_MUL_LO;
            cmd.src       = lepd_pkg::SRC_PROP;
            cmd.acc_clear = 1'b1;
            state_in      = ST_KP_HI;
         end
         ST_KP_HI: begin
            cmd.op   = lepd_pkg::DP_MUL_HI;
            cmd.src  = lepd_pkg::SRC_PROP;
            state_in = ST_KD_LO;
         end
         ST_KD_LO: begin
            cmd.op   = lepd_pkg::DP_MUL_LO;
            cmd.src  = lepd_pkg::SRC_DERIV;
            state_in = ST_KD_HI;
         end
         ST_KD_HI: begin
            cmd.op   = lepd_pkg::DP_MUL_HI;
            cmd.src  = lepd_pkg::SRC_DERIV;
            state_in = ST_ROUND_T;
         end
         ST_ROUND_T: begin
            cmd.op   = lepd_pkg::DP_ROUND;
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            if (out_free) begin
               cmd.op    = lepd_pkg::DP_TARGET;
               out_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SEARCH: begin
            if (out_free) begin
               cmd.op    = lepd_pkg::DP_SEARCH;
               out_write = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid: set on write, cleared when the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_write) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/lepd_dp.sv
// Datapath for the line-error PD block: error capture, shared split
// multiplier with accumulator, rounding, filter update, clamp and result
// register. Uses lepd_pkg; driven by lepd_ctrl commands.
module lepd_dp #(
   parameter int ERROR_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lepd_pkg::dp_cmd_type cmd,
   input  lepd_pkg::cfg_type    cfg,
   input  logic                 gain_clear,
   input  lepd_pkg::req_type    req_data,
   output lepd_pkg::rsp_type    rsp_data
);

   localparam int OPA = lepd_pkg::OPA_BITS;
   localparam int ACC = lepd_pkg::ACC_BITS;
   localparam int RB  = lepd_pkg::RATE_BITS;
   localparam int RND = lepd_pkg::RND_BITS;
   localparam int TW  = RND + 1;
   localparam int LO  = lepd_pkg::LO_BITS;
   localparam int HB  = lepd_pkg::HI_BITS;
   localparam int OB  = lepd_pkg::OPB_BITS;

   localparam logic signed [32:0] EMAX =
      33'((64'sd1 <<< (ERROR_BITS - 1)) - 64'sd1);
   localparam logic signed [32:0] EMIN = -EMAX - 33'sd1;

   localparam logic signed [ACC-1:0] ACC_RATE_MAX = ACC'((64'sd1 <<< (RB - 1)) - 64'sd1);
   localparam logic signed [ACC-1:0] ACC_RATE_MIN = -ACC_RATE_MAX - ACC'(1);
   localparam logic signed [TW-1:0]  SUM_RATE_MAX = TW'((64'sd1 <<< (RB - 1)) - 64'sd1);
   localparam logic signed [TW-1:0]  SUM_RATE_MIN = -SUM_RATE_MAX - TW'(1);
   localparam logic signed [TW-1:0]  TURN_DEAD    = TW'(16);

   // State and working registers
   logic signed [ERROR_BITS-1:0] e_ff, e_in;
   logic signed [ERROR_BITS-1:0] prior_ff, prior_in;
   logic signed [ERROR_BITS:0]   diff_ff, diff_in;
   logic signed [OPA-1:0]        delta_ff, delta_in;
   logic signed [RB-1:0]         smoothed_ff, smoothed_in;
   logic signed [ACC-1:0]        acc_ff, acc_in;
   logic signed [RND-1:0]        rnd_ff, rnd_in;
   logic                         turn_ff, turn_in;
   lepd_pkg::rsp_type            rsp_ff, rsp_in;

   // Combinational helpers
   logic signed [32:0]                        p_ext;
   logic signed [32:0]                        p_sat;
   logic signed [OPA-1:0]                     a_sel;
   logic [OB-1:0]                             b_sel;
   logic [lepd_pkg::LO_PROD_BITS-1:0]         lo_prod;
   logic signed [HB-1:0]                      a_hi;
   logic signed [lepd_pkg::HI_PROD_BITS-1:0]  hi_prod;
   logic signed [ACC-1:0]                     mul_term;
   logic signed [ACC-1:0]                     acc_base;
   logic signed [ACC-1:0]                     rnd_sum;
   logic signed [RB-1:0]                      rate_sat;
   logic signed [TW-1:0]                      smooth_sum;
   logic signed [TW-1:0]                      rnd_x;
   logic signed [TW-1:0]                      t_neg;
   logic signed [TW-1:0]                      lim;
   logic signed [TW-1:0]                      t_clamp;
   logic signed [lepd_pkg::YAW_BITS-1:0]      search_mag;

   // Input error saturated to the error width
   assign p_ext = 33'($signed(req_data.position_error));
   assign p_sat = (p_ext > EMAX) ? EMAX : ((p_ext < EMIN) ? EMIN : p_ext);

   // Multiplier operand select
   always_comb begin
      case (cmd.src)
         lepd_pkg::SRC_RATE: begin
            a_sel = OPA'(diff_ff);
            b_sel = cfg.sample_rate_hz;
         end
         lepd_pkg::SRC_ALPHA: begin
            a_sel = delta_ff;
            b_sel = cfg.rate_filter_alpha;
         end
         lepd_pkg::SRC_PROP: begin
            a_sel = OPA'(e_ff);
            b_sel = cfg.prop_gain;
         end
         default: begin
            a_sel = OPA'(smoothed_ff);
            b_sel = cfg.deriv_gain;
         end
      endcase
   end

   // Split product: unsigned low slice, signed high slice shifted up
   assign a_hi    = a_sel[OPA-1:LO];
   assign lo_prod = lepd_pkg::LO_PROD_BITS'(a_sel[LO-1:0])
                  * lepd_pkg::LO_PROD_BITS'(b_sel);
   assign hi_prod = lepd_pkg::HI_PROD_BITS'(a_hi)
                  * $signed(lepd_pkg::HI_PROD_BITS'(b_sel));
   assign mul_term = (cmd.op == lepd_pkg::DP_MUL_HI) ? $signed({hi_prod, {LO{1'b0}}})
                                                    : $signed(ACC'(lo_prod));
   assign acc_base = cmd.acc_clear ? '0 : acc_ff;

   // Divide by 2^16, half away from zero
   assign rnd_sum = acc_ff + (acc_ff[ACC-1] ? ACC'(32767) : ACC'(32768));

   // Raw rate saturated to the filter width
   assign rate_sat = (acc_ff > ACC_RATE_MAX) ? ACC_RATE_MAX[RB-1:0]
                   : ((acc_ff < ACC_RATE_MIN) ? ACC_RATE_MIN[RB-1:0] : acc_ff[RB-1:0]);

   // Filter update and target clamp
   assign smooth_sum = TW'(smoothed_ff) + TW'(rnd_ff);
   assign rnd_x      = TW'(rnd_ff);
   assign t_neg      = cfg.invert_sign ? -rnd_x : rnd_x;
   assign lim        = $signed(TW'(cfg.yaw_limit));
   assign t_clamp    = (t_neg > lim) ? lim : ((t_neg < -lim) ? -lim : t_neg);
   assign search_mag = $signed(lepd_pkg::YAW_BITS'(cfg.search_yaw_rate));

   always_comb begin
      e_in        = e_ff;
      prior_in    = prior_ff;
      diff_in     = diff_ff;
      delta_in    = delta_ff;
      smoothed_in = smoothed_ff;
      acc_in      = acc_ff;
      rnd_in      = rnd_ff;
      turn_in     = turn_ff;
      rsp_in      = rsp_ff;
      case (cmd.op)
         lepd_pkg::DP_CAPTURE: e_in = p_sat[ERROR_BITS-1:0];
         lepd_pkg::DP_DIFF:    diff_in = (ERROR_BITS+1)'(e_ff) - (ERROR_BITS+1)'(prior_ff);
         lepd_pkg::DP_MUL_LO,
         lepd_pkg::DP_MUL_HI:  acc_in = acc_base + mul_term;
         lepd_pkg::DP_FILTER: begin
            delta_in = OPA'(rate_sat) - OPA'(smoothed_ff);
            prior_in = e_ff;
         end
         lepd_pkg::DP_ROUND:   rnd_in = rnd_sum[ACC-1:lepd_pkg::FRAC_BITS];
         lepd_pkg::DP_SMOOTH: begin
            if (smooth_sum > SUM_RATE_MAX) begin
               smoothed_in = SUM_RATE_MAX[RB-1:0];
            end else if (smooth_sum < SUM_RATE_MIN) begin
               smoothed_in = SUM_RATE_MIN[RB-1:0];
            end else begin
               smoothed_in = smooth_sum[RB-1:0];
            end
         end
         lepd_pkg::DP_TARGET: begin
            if ((t_clamp > TURN_DEAD) || (t_clamp < -TURN_DEAD)) begin
               turn_in = t_clamp[TW-1];
            end
            rsp_in.yaw_rate_target = t_clamp[lepd_pkg::YAW_BITS-1:0];
            rsp_in.searching       = 1'b0;
            rsp_in.turn_left       = ((t_clamp > TURN_DEAD) || (t_clamp < -TURN_DEAD))
                                   ? t_clamp[TW-1] : turn_ff;
         end
         lepd_pkg::DP_SEARCH: begin
            rsp_in.yaw_rate_target = turn_ff ? -search_mag : search_mag;
            rsp_in.searching       = 1'b1;
            rsp_in.turn_left       = turn_ff;
         end
         default: ;
      endcase
      // Gain writes restart the derivative history
      if (gain_clear) begin
         prior_in    = '0;
         smoothed_in = '0;
      end
   end

   // Controller state of the filter
   always_ff @(posedge clock) begin
      if (reset) begin
         prior_ff    <= '0;
         smoothed_ff <= '0;
         turn_ff     <= 1'b0;
      end else begin
         prior_ff    <= prior_in;
         smoothed_ff <= smoothed_in;
         turn_ff     <= turn_in;
      end
   end

   // Working registers and result
   always_ff @(posedge clock) begin
      e_ff     <= e_in;
      diff_ff  <= diff_in;
      delta_ff <= delta_in;
      acc_ff   <= acc_in;
      rnd_ff   <= rnd_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/line_error_pd_yaw_rate_target.sv
// Top level of the line-error PD yaw-rate target block.
// Instantiates lepd_csr, lepd_ctrl and lepd_dp; types come from lepd_pkg.
//
// Usage:
//   req channel: one beat per control sample, carrying the line position
//   error (Q8.8) and a line-seen flag. req_stall is high while an item is
//   being worked on.
//   rsp channel: one beat per request with the yaw-rate target (1/16 deg/s),
//   the searching flag and the stored turn sign.
//   csr channel: register writes, index 0..6, always ready; write only while
//   no item is in flight. Gain writes clear the error history and filter.
// Sequence:
//   Line seen: the result is registered in the last step of the sequence,
//   and the next request is taken only once it is written. The work is a
//   sequence of 41x16 products on one shared multiplier, split into 24x16
//   and 17x16 slices (low step, then high step), plus rounding, filter and
//   clamp. Line lost: the search result is registered in the search step.
// Reset: synchronous; configuration returns to defaults, history is cleared.
// A stalled result holds in the output register; the block still accepts the
// next request and waits in its last step until the output register frees.
module line_error_pd_yaw_rate_target #(
   parameter int ERROR_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lepd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lepd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lepd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [lepd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   lepd_pkg::cfg_type    cfg;
   lepd_pkg::dp_cmd_type cmd;
   logic                 gain_clear;

   // Configuration registers
   lepd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .gain_clear (gain_clear)
   );

   // Sequencer
   lepd_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_line_seen (req_data.line_seen),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd)
   );

   // Arithmetic
   lepd_dp #(
      .ERROR_BITS (ERROR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg),
      .gain_clear (gain_clear),
      .req_data   (req_data),
      .rsp_data   (rsp_data)
   );

endmodule
